@@ sv/assert_macros.svh @@
// assertion helpers used by tlmic_core
// each macro expects clk and rst_n in the scope that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tlmic_pkg.sv @@
// types and constants for the three-level masked interrupt controller
// no dependencies; used by tlmic_core and the top level
package tlmic_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned MASK_COUNT  = 9;
    localparam int unsigned LEVEL_COUNT = 3;

    // read composition constants
    localparam logic [DATA_W-1:0] LOW_STATUS_BITS = 32'h3FFF_FFFF;
    localparam logic [DATA_W-1:0] EXT_SUMMARY_BIT = 32'h4000_0000;
    localparam logic [DATA_W-1:0] ERR_SUMMARY_BIT = 32'h8000_0000;

    // operation codes
    typedef enum logic [1:0] {
        OP_RAISE  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    // raise group codes
    localparam logic [1:0] GRP_NORMAL   = 2'd0;
    localparam logic [1:0] GRP_EXTERNAL = 2'd1;
    localparam logic [1:0] GRP_ERROR    = 2'd2;

    // register select codes
    localparam logic [3:0] SEL_NORMAL     = 4'd0;
    localparam logic [3:0] SEL_EXTERNAL   = 4'd1;
    localparam logic [3:0] SEL_ERROR      = 4'd2;
    localparam logic [3:0] SEL_MASK_FIRST = 4'd3;
    localparam logic [3:0] SEL_MASK_LAST  = 4'd11;

    // one request as held in the input register
    typedef struct packed {
        opcode_t           opcode;
        logic [1:0]        source_group;
        logic [4:0]        source_bit;
        logic [3:0]        register_select;
        logic [DATA_W-1:0] write_data;
    } item_t;

    // one response as held in the output register
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              level6_request;
        logic              level4_request;
        logic              level2_request;
    } result_t;

endpackage

@@ sv/tlmic_core.sv @@
// status and mask registers with their update and response logic
// depends on tlmic_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlmic_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec,
    input  tlmic_pkg::item_t  item,
    output tlmic_pkg::result_t res
);

    logic [tlmic_pkg::DATA_W-1:0] status_normal_reg, status_normal_next;
    logic [tlmic_pkg::DATA_W-1:0] status_external_reg, status_external_next;
    logic [tlmic_pkg::DATA_W-1:0] status_error_reg, status_error_next;
    logic [tlmic_pkg::DATA_W-1:0] mask_reg  [tlmic_pkg::MASK_COUNT];
    logic [tlmic_pkg::DATA_W-1:0] mask_next [tlmic_pkg::MASK_COUNT];
    logic [tlmic_pkg::DATA_W-1:0] one_hot;
    logic [3:0]                   mask_idx;
    logic [tlmic_pkg::LEVEL_COUNT-1:0] level_line;

    assign one_hot  = tlmic_pkg::DATA_W'(1) << item.source_bit;
    assign mask_idx = item.register_select - tlmic_pkg::SEL_MASK_FIRST;

    // next state for the request in the input register
    always_comb
    begin
        status_normal_next   = status_normal_reg;
        status_external_next = status_external_reg;
        status_error_next    = status_error_reg;
        for (int i = 0; i < tlmic_pkg::MASK_COUNT; i++)
        begin
            mask_next[i] = mask_reg[i];
        end
        if (exec)
        begin
            unique case (item.opcode)
                tlmic_pkg::OP_RAISE:
                begin
                    unique case (item.source_group)
                        tlmic_pkg::GRP_NORMAL:   status_normal_next   = status_normal_reg | one_hot;
                        tlmic_pkg::GRP_EXTERNAL: status_external_next = status_external_reg | one_hot;
                        tlmic_pkg::GRP_ERROR:    status_error_next    = status_error_reg | one_hot;
                        default: ;
                    endcase
                end
                tlmic_pkg::OP_CANCEL:
                begin
                    status_external_next = status_external_reg & ~one_hot;
                end
                tlmic_pkg::OP_WRITE:
                begin
                    // write one to clear on normal and error status, plain load on masks
                    unique case (item.register_select) inside
                        tlmic_pkg::SEL_NORMAL:
                            status_normal_next = status_normal_reg & ~item.write_data;
                        tlmic_pkg::SEL_ERROR:
                            status_error_next = status_error_reg & ~item.write_data;
                        [tlmic_pkg::SEL_MASK_FIRST:tlmic_pkg::SEL_MASK_LAST]:
                            mask_next[mask_idx] = item.write_data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_normal_reg   <= '0;
            status_external_reg <= '0;
            status_error_reg    <= '0;
            for (int i = 0; i < tlmic_pkg::MASK_COUNT; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else
        begin
            status_normal_reg   <= status_normal_next;
            status_external_reg <= status_external_next;
            status_error_reg    <= status_error_next;
            for (int i = 0; i < tlmic_pkg::MASK_COUNT; i++)
            begin
                mask_reg[i] <= mask_next[i];
            end
        end
    end

    // level lines from the updated state; index 0 is level 6
    always_comb
    begin
        for (int l = 0; l < tlmic_pkg::LEVEL_COUNT; l++)
        begin
            level_line[l] = |((status_normal_next & mask_next[l])
                            | (status_external_next & mask_next[tlmic_pkg::LEVEL_COUNT + l])
                            | (status_error_next & mask_next[2*tlmic_pkg::LEVEL_COUNT + l]));
        end
    end

    // response word
    always_comb
    begin
        res.read_data = '0;
        if (item.opcode == tlmic_pkg::OP_READ)
        begin
            res.read_data = (status_normal_reg & tlmic_pkg::LOW_STATUS_BITS)
                          | ((|status_external_reg) ? tlmic_pkg::EXT_SUMMARY_BIT : '0)
                          | ((|status_error_reg) ? tlmic_pkg::ERR_SUMMARY_BIT : '0);
        end
        res.level6_request = level_line[0];
        res.level4_request = level_line[1];
        res.level2_request = level_line[2];
    end

    // checks
    `ASSERT_NEXT(a_idle_holds, !exec, $stable(status_normal_reg) && $stable(status_external_reg) && $stable(status_error_reg), "status changed without a request")
    `ASSERT_NEXT(a_ext_clear_only_cancel, !(exec && item.opcode == tlmic_pkg::OP_CANCEL), ($past(status_external_reg) & ~status_external_reg) == '0, "external bit cleared by other than cancel")
    `ASSERT_IMPL(a_read_zero, item.opcode != tlmic_pkg::OP_READ, res.read_data == '0, "read data nonzero outside a read")
    `ASSERT_ALWAYS(a_no_mask_no_line, !(mask_next[0] == '0 && mask_next[3] == '0 && mask_next[6] == '0) || !res.level6_request, "level 6 raised with all level 6 masks clear")

endmodule

@@ sv/three_level_masked_interrupt_controller_top.sv @@
// top level of the three-level masked interrupt controller
// depends on tlmic_pkg and tlmic_core
//
// usage: requests enter on the item channel (item_valid/item_ready) carrying
// opcode, source_group, source_bit, register_select and write_data. each
// request gives exactly one response on the result channel
// (result_valid/result_ready) with read_data and the three level lines as
// they stand after that request's update.
// a request accepted into the input register is executed as it moves on into
// the output register, and its response is valid from that point.
// throughput: one request per cycle while result_ready is high; the input and
// the output register let a new request in while the previous response waits.
// stall: while result_ready is low the response holds, the request in the
// input register waits, and item_ready drops once that register is full.
// reset: all status and mask words clear to zero and both channels empty.
module three_level_masked_interrupt_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  source_group,
    input  logic [4:0]  source_bit,
    input  logic [3:0]  register_select,
    input  logic [31:0] write_data,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] read_data,
    output logic        level6_request,
    output logic        level4_request,
    output logic        level2_request
);

    logic                 in_valid_reg;
    tlmic_pkg::item_t     item_reg;
    logic                 out_valid_reg;
    tlmic_pkg::result_t   result_reg;
    tlmic_pkg::result_t   core_res;
    logic                 advance;

    // request moves into the output register when that register is free
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.opcode          <= tlmic_pkg::opcode_t'(opcode);
            item_reg.source_group    <= source_group;
            item_reg.source_bit      <= source_bit;
            item_reg.register_select <= register_select;
            item_reg.write_data      <= write_data;
        end
    end

    tlmic_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (advance),
        .item  (item_reg),
        .res   (core_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_res;
        end
    end

    assign result_valid   = out_valid_reg;
    assign read_data      = result_reg.read_data;
    assign level6_request = result_reg.level6_request;
    assign level4_request = result_reg.level4_request;
    assign level2_request = result_reg.level2_request;

endmodule

@@ tb/sv/three_level_masked_interrupt_controller_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for three_level_masked_interrupt_controller_top
// uses tlmic_pkg for codes and types; keeps its own model of status, masks and level lines
module three_level_masked_interrupt_controller_top_tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned MAX_IDLE      = 18;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  opcode;
    logic [1:0]  source_group;
    logic [4:0]  source_bit;
    logic [3:0]  register_select;
    logic [31:0] write_data;
    logic        result_valid;
    logic        result_ready;
    logic [31:0] read_data;
    logic        level6_request;
    logic        level4_request;
    logic        level2_request;

    // model state of the controller
    logic [tlmic_pkg::DATA_W-1:0] model_normal;
    logic [tlmic_pkg::DATA_W-1:0] model_external;
    logic [tlmic_pkg::DATA_W-1:0] model_error;
    logic [tlmic_pkg::DATA_W-1:0] model_masks [tlmic_pkg::MASK_COUNT];

    tlmic_pkg::result_t expected_responses [$];
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned requests_sent;
    int unsigned responses_checked;
    int unsigned mask_writes;
    int unsigned reads_sent;
    logic        idling_on;
    logic        hold_request;

    three_level_masked_interrupt_controller_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .opcode          (opcode),
        .source_group    (source_group),
        .source_bit      (source_bit),
        .register_select (register_select),
        .write_data      (write_data),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .read_data       (read_data),
        .level6_request  (level6_request),
        .level4_request  (level4_request),
        .level2_request  (level2_request)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // level line: lvl 0 is level 6, 1 is level 4, 2 is level 2
    function automatic logic level_hit(int unsigned lvl);
        logic [tlmic_pkg::DATA_W-1:0] hit;
        hit = (model_normal & model_masks[lvl])
            | (model_external & model_masks[tlmic_pkg::LEVEL_COUNT + lvl])
            | (model_error & model_masks[2 * tlmic_pkg::LEVEL_COUNT + lvl]);
        return hit != '0;
    endfunction

    // update the model with one request and return the response it causes
    function automatic tlmic_pkg::result_t apply_request(tlmic_pkg::item_t req);
        tlmic_pkg::result_t           resp;
        logic [tlmic_pkg::DATA_W-1:0] one_hot;
        one_hot = 32'd1 << req.source_bit;
        resp = '0;
        case (req.opcode)
            tlmic_pkg::OP_RAISE:
            begin
                if (req.source_group == tlmic_pkg::GRP_NORMAL)
                    model_normal = model_normal | one_hot;
                else if (req.source_group == tlmic_pkg::GRP_EXTERNAL)
                    model_external = model_external | one_hot;
                else if (req.source_group == tlmic_pkg::GRP_ERROR)
                    model_error = model_error | one_hot;
            end
            tlmic_pkg::OP_CANCEL:
                model_external = model_external & ~one_hot;
            tlmic_pkg::OP_WRITE:
            begin
                if (req.register_select == tlmic_pkg::SEL_NORMAL)
                    model_normal = model_normal & ~req.write_data;
                else if (req.register_select == tlmic_pkg::SEL_ERROR)
                    model_error = model_error & ~req.write_data;
                else if (req.register_select >= tlmic_pkg::SEL_MASK_FIRST &&
                         req.register_select <= tlmic_pkg::SEL_MASK_LAST)
                begin
                    model_masks[req.register_select - tlmic_pkg::SEL_MASK_FIRST] =
                        req.write_data;
                    mask_writes++;
                end
            end
            default:
            begin
                resp.read_data = model_normal & tlmic_pkg::LOW_STATUS_BITS;
                if (model_external != '0)
                    resp.read_data = resp.read_data | tlmic_pkg::EXT_SUMMARY_BIT;
                if (model_error != '0)
                    resp.read_data = resp.read_data | tlmic_pkg::ERR_SUMMARY_BIT;
                reads_sent++;
            end
        endcase
        resp.level6_request = level_hit(0);
        resp.level4_request = level_hit(1);
        resp.level2_request = level_hit(2);
        return resp;
    endfunction

    function automatic tlmic_pkg::item_t make_request(tlmic_pkg::opcode_t op, logic [1:0] grp,
                                                      logic [4:0] bitpos, logic [3:0] sel,
                                                      logic [31:0] data);
        tlmic_pkg::item_t req;
        req.opcode          = op;
        req.source_group    = grp;
        req.source_bit      = bitpos;
        req.register_select = sel;
        req.write_data      = data;
        return req;
    endfunction

    // random request, weighted toward raises and writes so status keeps moving
    function automatic tlmic_pkg::item_t random_request();
        tlmic_pkg::item_t req;
        int unsigned      pick;
        req.source_group    = 2'($urandom_range(0, 3));
        req.source_bit      = 5'($urandom_range(0, 31));
        req.register_select = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       req.write_data = '0;
            1:       req.write_data = '1;
            2:       req.write_data = 32'd1 << $urandom_range(0, 31);
            default: req.write_data = $urandom();
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req.opcode = tlmic_pkg::OP_RAISE;
        else if (pick < 50)
            req.opcode = tlmic_pkg::OP_CANCEL;
        else if (pick < 80)
            req.opcode = tlmic_pkg::OP_WRITE;
        else
            req.opcode = tlmic_pkg::OP_READ;
        return req;
    endfunction

    // drive one request and wait for it to be taken
    task automatic send_request(tlmic_pkg::item_t req);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        opcode          <= req.opcode;
        source_group    <= req.source_group;
        source_bit      <= req.source_bit;
        register_select <= req.register_select;
        write_data      <= req.write_data;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_responses.push_back(apply_request(req));
        requests_sent++;
    endtask

    task automatic send_random(int unsigned count);
        repeat (count)
            send_request(random_request());
    endtask

    // raises in every group, ignored group code, read summary bits
    task automatic test_raise_and_read();
        send_request(make_request(tlmic_pkg::OP_RAISE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_RAISE, tlmic_pkg::GRP_NORMAL, 5'd31,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_RAISE, tlmic_pkg::GRP_NORMAL, 5'd30,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_READ, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_RAISE, tlmic_pkg::GRP_EXTERNAL, 5'd31,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_RAISE, tlmic_pkg::GRP_ERROR, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_RAISE, 2'd3, 5'd5,
                                  tlmic_pkg::SEL_NORMAL, '1));
        send_request(make_request(tlmic_pkg::OP_READ, 2'd3, 5'd31, 4'd15, '1));
    endtask

    // mask words drive the level lines
    task automatic test_mask_levels();
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_MASK_FIRST, '1));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  4'd7, 32'h8000_0000));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_MASK_LAST, 32'h0000_0001));
        send_request(make_request(tlmic_pkg::OP_READ, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_MASK_FIRST, '0));
    endtask

    // write-one-to-clear, ignored external write, ignored selects, cancel
    task automatic test_clear_and_cancel();
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_EXTERNAL, '1));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  4'd12, '1));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  4'd15, '1));
        send_request(make_request(tlmic_pkg::OP_READ, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_CANCEL, tlmic_pkg::GRP_ERROR, 5'd31,
                                  tlmic_pkg::SEL_NORMAL, '0));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, 32'hC000_0001));
        send_request(make_request(tlmic_pkg::OP_WRITE, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_ERROR, '1));
        send_request(make_request(tlmic_pkg::OP_READ, tlmic_pkg::GRP_NORMAL, 5'd0,
                                  tlmic_pkg::SEL_NORMAL, '0));
    endtask

    // long output stall while requests keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        send_random(100);
    endtask

    task automatic test_random_traffic(int unsigned count);
        send_random(count);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_full_rate(int unsigned count);
        idling_on = 1'b0;
        send_random(count);
    endtask

    task automatic finish_run();
        item_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d requests (%0d reads, %0d mask writes), %0d responses checked",
                 requests_sent, reads_sent, mask_writes, responses_checked);
        $display("directed raise/clear/cancel/mask cases, random traffic, a %0d-cycle stall",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    // stimulus
    initial
    begin
        model_normal   = '0;
        model_external = '0;
        model_error    = '0;
        foreach (model_masks[i])
            model_masks[i] = '0;
        mismatch_count    = 0;
        requests_sent     = 0;
        responses_checked = 0;
        mask_writes       = 0;
        reads_sent        = 0;
        idling_on         = 1'b1;
        hold_request      = 1'b0;
        rst_n           <= 1'b0;
        item_valid      <= 1'b0;
        opcode          <= tlmic_pkg::OP_RAISE;
        source_group    <= tlmic_pkg::GRP_NORMAL;
        source_bit      <= '0;
        register_select <= tlmic_pkg::SEL_NORMAL;
        write_data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_raise_and_read();
        test_mask_levels();
        test_clear_and_cancel();
        test_random_traffic(400);
        test_backpressure();
        test_random_traffic(350);
        test_full_rate(100);
        finish_run();
    end

    // response side: random stall bursts, one long hold on request
    initial
    begin
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, MAX_IDLE) - 1) @(posedge clk);
            end
            else
                result_ready <= 1'b1;
        end
    end

    // compare each response with the oldest expectation
    always @(posedge clk)
    begin
        tlmic_pkg::result_t exp_resp;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response with no request outstanding: read_data %h", read_data);
                mismatch_count++;
            end
            else
            begin
                exp_resp = expected_responses.pop_front();
                responses_checked++;
                if (read_data !== exp_resp.read_data)
                begin
                    $error("read_data expected %h actual %h", exp_resp.read_data, read_data);
                    mismatch_count++;
                end
                if (level6_request !== exp_resp.level6_request)
                begin
                    $error("level6_request expected %b actual %b",
                           exp_resp.level6_request, level6_request);
                    mismatch_count++;
                end
                if (level4_request !== exp_resp.level4_request)
                begin
                    $error("level4_request expected %b actual %b",
                           exp_resp.level4_request, level4_request);
                    mismatch_count++;
                end
                if (level2_request !== exp_resp.level2_request)
                begin
                    $error("level2_request expected %b actual %b",
                           exp_resp.level2_request, level2_request);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_responses.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
